[src/tbrl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrl_pkg
// Widths, constants and shared types of the token bucket rate limiter.
// ----------------------------------------------------------------------------
package tbrl_pkg;

  // field and state widths
  localparam int TOKEN_W   = 48;
  localparam int RATE_W    = 48;
  localparam int SIZE_W    = 48;
  localparam int ELAPSED_W = 32;
  localparam int WAIT_W    = 32;

  // time base: ticks per second
  localparam int TICKS_PER_SECOND = 1000;

  // serial multiplier: RATE_W x ELAPSED_W, one multiplier bit per cycle
  localparam int PROD_W    = RATE_W + ELAPSED_W;
  localparam int MUL_CNT_W = $clog2(ELAPSED_W);

  // serial divider: 64-bit dividend, one quotient bit per cycle
  localparam int DVD_W     = 64;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam logic [TOKEN_W-1:0]   TOKEN_MAX   = '1;
  localparam logic [WAIT_W-1:0]    WAIT_MAX    = '1;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic [ELAPSED_W-1:0] TICKS_MPLIER  = ELAPSED_W'(TICKS_PER_SECOND);
  localparam logic [RATE_W-1:0]    TICKS_DIVISOR = RATE_W'(TICKS_PER_SECOND);

  // item opcodes
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[src/tbrl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrl_if
// Channel interfaces of the rate limiter: config write, input item, result.
// ----------------------------------------------------------------------------

// rate register write channel
interface tbrl_cfg_if import tbrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_bytes_per_s;

  modport source (output valid, output rate_bytes_per_s, input ready);
  modport sink   (input valid, input rate_bytes_per_s, output ready);
endinterface

// input item channel
interface tbrl_item_if import tbrl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [SIZE_W-1:0] request_size;

  modport source (output valid, output op, output request_size, input ready);
  modport sink   (input valid, input op, input request_size, output ready);
endinterface

// result channel
interface tbrl_res_if import tbrl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [WAIT_W-1:0]  wait_ms;
  logic               busy_res;
  logic [TOKEN_W-1:0] tokens_left;

  modport source (output valid, output granted, output wait_ms, output busy_res,
                  output tokens_left, input ready);
  modport sink   (input valid, input granted, input wait_ms, input busy_res,
                  input tokens_left, output ready);
endinterface

[src/token_bucket_rate_limiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_bucket_rate_limiter
// Byte token bucket: ticks, byte requests and restarts in, one result out.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : writes the rate register (bytes per second); always ready.
//            Write only while no item is in flight.
//   item   : op tick / request / restart, plus request_size. One item is
//            worked on at a time; ready is low while an item is at work.
//   result : one beat per item: granted, wait_ms, busy_res, tokens_left.
// Steps, accept to result valid:
//   tick, restart, unused op, request that fits the bucket : result
//     valid in the cycle after accept.
//   request that needs a refill : serial multiply of rate by elapsed
//     time, serial divide by the tick rate, saturating add, check.
//   request rejected after refill : a second multiply and divide give
//     the wait time from the shortfall and the rate.
//   The multiply and divide run on the bit-serial multiplier and divider.
// Reset: rate, bucket level and elapsed time clear to zero.
// A stalled result holds in the output register; the next item is taken
// in the same cycle the held beat is taken, and not before.
// ----------------------------------------------------------------------------
module token_bucket_rate_limiter import tbrl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tbrl_cfg_if.sink    cfg,
  tbrl_item_if.sink   item,
  tbrl_res_if.source  result
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_MUL_FILL = 7'b0000010,
    S_DIV_FILL = 7'b0000100,
    S_ADD_FILL = 7'b0001000,
    S_JUDGE    = 7'b0010000,
    S_MUL_WAIT = 7'b0100000,
    S_DIV_WAIT = 7'b1000000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [RATE_W-1:0]    rate_bytes_per_s;
  logic [TOKEN_W-1:0]   token_level;
  logic [ELAPSED_W-1:0] elapsed_ms;
  logic [SIZE_W-1:0]    req_size;

  logic                 res_valid;
  logic                 res_granted;
  logic [WAIT_W-1:0]    res_wait;
  logic                 res_busy;
  logic [TOKEN_W-1:0]   res_tokens;

  logic                 in_fire;
  op_t                  item_op;
  logic                 rate_zero;
  logic                 fits_now;
  logic                 fits_judge;
  logic [TOKEN_W-1:0]   shortfall;

  logic                 mul_start;
  logic [RATE_W-1:0]    mul_mcand;
  logic [ELAPSED_W-1:0] mul_mplier;
  unit_stat_t           mul_stat;
  logic [PROD_W-1:0]    mul_product;

  logic                 div_start;
  logic [DVD_W-1:0]     div_dividend;
  logic [RATE_W-1:0]    div_divisor;
  unit_stat_t           div_stat;
  logic [DVD_W-1:0]     div_quotient;

  logic [DVD_W-1:0]     prod_sat;
  logic [DVD_W:0]       fill_sum;
  logic                 fill_sat;
  logic                 wait_sat;
  logic [WAIT_W-1:0]    wait_val;

  logic                 res_load;
  logic                 load_granted;
  logic [WAIT_W-1:0]    load_wait;
  logic [TOKEN_W-1:0]   load_tokens;

  // handshakes
  assign cfg.ready  = 1'b1;
  assign item.ready = (state == S_IDLE) && (!res_valid || result.ready) &&
                      !mul_stat.busy && !div_stat.busy;
  assign in_fire    = item.valid && item.ready;
  assign item_op    = op_t'(item.op);

  // bucket checks
  assign rate_zero  = (rate_bytes_per_s == '0);
  assign fits_now   = (token_level >= item.request_size);
  assign fits_judge = (token_level >= req_size);
  assign shortfall  = req_size - token_level;

  // refill: saturate product to 64 bits, add quotient plus one, saturate bucket
  assign prod_sat = (|mul_product[PROD_W-1:DVD_W]) ? {DVD_W{1'b1}}
                                                   : mul_product[DVD_W-1:0];
  assign fill_sum = {1'b0, div_quotient} + {{(DVD_W+1-TOKEN_W){1'b0}}, token_level}
                    + {{DVD_W{1'b0}}, 1'b1};
  assign fill_sat = |fill_sum[DVD_W:TOKEN_W];

  // wait: quotient plus one, saturating
  assign wait_sat = (|div_quotient[DVD_W-1:WAIT_W]) ||
                    (div_quotient[WAIT_W-1:0] == WAIT_MAX);
  assign wait_val = wait_sat ? WAIT_MAX : div_quotient[WAIT_W-1:0] + 1'b1;

  // sequencer, unit starts and result load
  always_comb begin
    state_next   = state;
    mul_start    = 1'b0;
    mul_mcand    = rate_bytes_per_s;
    mul_mplier   = elapsed_ms;
    div_start    = 1'b0;
    div_dividend = prod_sat;
    div_divisor  = TICKS_DIVISOR;
    res_load     = 1'b0;
    load_granted = 1'b0;
    load_wait    = '0;
    load_tokens  = token_level;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          unique case (item_op)
            OP_TICK: begin
              res_load = 1'b1;
            end
            OP_REQUEST: begin
              if (fits_now) begin
                res_load     = 1'b1;
                load_granted = 1'b1;
                load_tokens  = token_level - item.request_size;
              end else begin
                mul_start  = 1'b1;
                state_next = S_MUL_FILL;
              end
            end
            OP_RESTART: begin
              res_load    = 1'b1;
              load_tokens = rate_bytes_per_s;
            end
            OP_NONE: begin
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_MUL_FILL: begin
        if (mul_stat.done) begin
          div_start  = 1'b1;
          state_next = S_DIV_FILL;
        end
      end
      S_DIV_FILL: begin
        if (div_stat.done) begin
          state_next = S_ADD_FILL;
        end
      end
      S_ADD_FILL: begin
        state_next = S_JUDGE;
      end
      S_JUDGE: begin
        if (fits_judge) begin
          res_load     = 1'b1;
          load_granted = 1'b1;
          load_tokens  = token_level - req_size;
          state_next   = S_IDLE;
        end else if (rate_zero) begin
          res_load   = 1'b1;
          load_wait  = WAIT_MAX;
          state_next = S_IDLE;
        end else begin
          mul_start  = 1'b1;
          mul_mcand  = shortfall;
          mul_mplier = TICKS_MPLIER;
          state_next = S_MUL_WAIT;
        end
      end
      S_MUL_WAIT: begin
        div_dividend = mul_product[DVD_W-1:0];
        div_divisor  = rate_bytes_per_s;
        if (mul_stat.done) begin
          div_start  = 1'b1;
          state_next = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          res_load   = 1'b1;
          load_wait  = wait_val;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control and bucket state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      rate_bytes_per_s <= '0;
      token_level      <= '0;
      elapsed_ms       <= '0;
      res_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        rate_bytes_per_s <= cfg.rate_bytes_per_s;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (in_fire) begin
        unique case (item_op)
          OP_TICK: begin
            if (elapsed_ms != ELAPSED_MAX) begin
              elapsed_ms <= elapsed_ms + 1'b1;
            end
          end
          OP_REQUEST: begin
            if (fits_now) begin
              token_level <= token_level - item.request_size;
            end
          end
          OP_RESTART: begin
            token_level <= rate_bytes_per_s;
            elapsed_ms  <= '0;
          end
          OP_NONE: begin
          end
          default: begin
          end
        endcase
      end else if (state == S_ADD_FILL) begin
        token_level <= fill_sat ? TOKEN_MAX : fill_sum[TOKEN_W-1:0];
        elapsed_ms  <= '0;
      end else if ((state == S_JUDGE) && fits_judge) begin
        token_level <= token_level - req_size;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_size <= item.request_size;
    end
    if (res_load) begin
      res_granted <= load_granted;
      res_wait    <= load_wait;
      res_busy    <= rate_zero;
      res_tokens  <= load_tokens;
    end
  end

  assign result.valid       = res_valid;
  assign result.granted     = res_granted;
  assign result.wait_ms     = res_wait;
  assign result.busy_res    = res_busy;
  assign result.tokens_left = res_tokens;

  tbrl_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .stat    (mul_stat),
    .product (mul_product)
  );

  tbrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

endmodule

[src/tbrl_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrl_mul
// Bit-serial shift-add multiplier, RATE_W x ELAPSED_W, one bit per cycle.
// ----------------------------------------------------------------------------
module tbrl_mul import tbrl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RATE_W-1:0] mcand,
  input  logic [ELAPSED_W-1:0] mplier,
  output unit_stat_t        stat,
  output logic [PROD_W-1:0] product
);

  logic                 busy;
  logic                 done;
  logic [MUL_CNT_W-1:0] cnt;
  logic [RATE_W-1:0]    mcand_q;
  logic [RATE_W-1:0]    hi;
  logic [ELAPSED_W-1:0] lo;
  logic [RATE_W:0]      sum;

  // add multiplicand into the upper half when the current multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand_q} : {(RATE_W+1){1'b0}});

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(ELAPSED_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // product shift register: multiplier bits leave at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_q <= mcand;
      hi      <= '0;
      lo      <= mplier;
    end else if (busy) begin
      hi <= sum[RATE_W:1];
      lo <= {sum[0], lo[ELAPSED_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = {hi, lo};

endmodule

[src/tbrl_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbrl_div
// Bit-serial restoring divider, DVD_W-bit dividend by RATE_W-bit divisor.
// ----------------------------------------------------------------------------
module tbrl_div import tbrl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [RATE_W-1:0] divisor,
  output unit_stat_t       stat,
  output logic [DVD_W-1:0] quotient
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W-1:0]    dsr;
  logic [RATE_W-1:0]    rem;
  logic [DVD_W-1:0]     dvd;
  logic [RATE_W:0]      rem_sh;
  logic [RATE_W+1:0]    diff;
  logic                 qbit;

  // trial subtract of the divisor from the shifted remainder
  assign rem_sh = {rem, dvd[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr};
  assign qbit   = ~diff[RATE_W+1];

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      rem <= qbit ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
      dvd <= {dvd[DVD_W-2:0], qbit};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte token bucket rate limiter. A directed
// table covers reset state, bucket and wait extremes and the zero-rate
// cases. Random traffic then runs over a series of rate settings, followed
// by a short tick run at full-scale rate that ends in a refill short of
// the request. Every result beat is checked field by field against the
// row's expectation or a predictor of the bucket.
// ----------------------------------------------------------------------------
module tb;
  import tbrl_pkg::*;

  localparam int    HALF_PERIOD  = 10;
  localparam int    RESET_CYCLES = 12;
  localparam int    GAP_MAX      = 4;
  localparam int    RANDOM_ITEMS = 750;
  localparam int    RATE_PHASES  = 8;
  localparam int    HOLD_AT_BEAT = 300;
  localparam int    HOLD_CYCLES  = 400;
  localparam int    PAUSE_AT     = 400;
  localparam int    BURST_TICKS  = 20;
  localparam int    TAIL_CYCLES  = 250;
  localparam int    SHOW_MAX     = 10;
  localparam longint CYCLE_LIMIT = 1500000;

  // one expected result beat
  typedef struct packed {
    logic               granted;
    logic [WAIT_W-1:0]  wait_ms;
    logic               busy_res;
    logic [TOKEN_W-1:0] tokens_left;
  } verdict_t;

  // one row of the directed script
  typedef struct {
    bit                wr_rate;  // row writes the rate register
    op_t               op;
    logic [SIZE_W-1:0] arg;      // request size, or the rate for a write
    bit                typed;    // expectation given in the row
    verdict_t          want;
  } step_row_t;

  logic clk;
  logic rst;

  tbrl_cfg_if  cfg_ch ();
  tbrl_item_if item_ch ();
  tbrl_res_if  res_ch ();

  token_bucket_rate_limiter dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  // predictor state
  logic [RATE_W-1:0]    rate_now;
  logic [TOKEN_W-1:0]   bucket_level;
  logic [ELAPSED_W-1:0] ms_since_refill;

  verdict_t  verdict_q[$];
  step_row_t script[$];

  bit     calm;
  int     beats_seen;
  int     bad_beats;
  int     items_sent;
  int     rate_writes;
  int     grants;
  int     rejects;
  longint cycles;

  // clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, verdict_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // bucket predictor: applies one item, returns its result
  function automatic verdict_t predict_bucket(op_t op, logic [SIZE_W-1:0] size);
    verdict_t     v;
    logic [127:0] prod;
    logic [63:0]  fresh;
    logic [63:0]  scaled;
    logic [63:0]  quo;
    v = '0;
    case (op)
      OP_TICK: begin
        if (ms_since_refill != ELAPSED_MAX) ms_since_refill = ms_since_refill + 1'b1;
      end
      OP_REQUEST: begin
        // refill only when the request does not fit
        if (bucket_level < size) begin
          prod  = 128'(rate_now) * 128'(ms_since_refill);
          fresh = (prod[127:64] != '0) ? '1 : prod[63:0];
          fresh = fresh / 64'(TICKS_PER_SECOND) + 64'd1;
          if (fresh > 64'(TOKEN_MAX) - 64'(bucket_level)) bucket_level = TOKEN_MAX;
          else bucket_level = bucket_level + fresh[TOKEN_W-1:0];
          ms_since_refill = '0;
        end
        if (bucket_level >= size) begin
          bucket_level = bucket_level - size;
          v.granted    = 1'b1;
        end else if (rate_now == '0) begin
          v.wait_ms = WAIT_MAX;
        end else begin
          scaled = 64'(size - bucket_level) * 64'(TICKS_PER_SECOND);
          quo    = scaled / 64'(rate_now);
          v.wait_ms = (quo >= 64'(WAIT_MAX)) ? WAIT_MAX : quo[WAIT_W-1:0] + 1'b1;
        end
      end
      OP_RESTART: begin
        bucket_level    = rate_now;
        ms_since_refill = '0;
      end
      default: ;
    endcase
    v.busy_res    = (rate_now == '0);
    v.tokens_left = bucket_level;
    return v;
  endfunction

  function automatic logic [SIZE_W-1:0] rand48();
    return SIZE_W'({$urandom, $urandom});
  endfunction

  // script builders
  task automatic add_item(op_t op, logic [SIZE_W-1:0] size);
    step_row_t r;
    r = '{wr_rate: 1'b0, op: OP_TICK, arg: '0, typed: 1'b0, want: '0};
    r.op  = op;
    r.arg = size;
    script.insert(script.size(), r);
  endtask

  task automatic add_check(op_t op, logic [SIZE_W-1:0] size, logic g,
                           logic [WAIT_W-1:0] w, logic b, logic [TOKEN_W-1:0] t);
    step_row_t r;
    r = '{wr_rate: 1'b0, op: OP_TICK, arg: '0, typed: 1'b0, want: '0};
    r.op    = op;
    r.arg   = size;
    r.typed = 1'b1;
    r.want  = '{granted: g, wait_ms: w, busy_res: b, tokens_left: t};
    script.insert(script.size(), r);
  endtask

  task automatic add_rate(logic [RATE_W-1:0] rate);
    step_row_t r;
    r = '{wr_rate: 1'b0, op: OP_TICK, arg: '0, typed: 1'b0, want: '0};
    r.wr_rate = 1'b1;
    r.arg     = rate;
    script.insert(script.size(), r);
  endtask

  // drop item valid and wait until every result is back
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_rate(logic [RATE_W-1:0] rate);
    settle();
    @(negedge clk);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.rate_bytes_per_s <= rate;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    rate_now = rate;
    rate_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // offer one item; on acceptance queue its expected result
  task automatic send_item(op_t op, logic [SIZE_W-1:0] size, bit typed, verdict_t want);
    int       gap;
    verdict_t v;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.op           <= op;
    item_ch.request_size <= size;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    v = predict_bucket(op, size);
    verdict_q.insert(verdict_q.size(), typed ? want : v);
    items_sent++;
  endtask

  // result ready: per-beat random stall, one long hold-off
  int stall_left;
  int beats_drawn;
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (beats_seen != beats_drawn) begin
        beats_drawn = beats_seen;
        stall_left  = calm ? 0 : $urandom_range(0, GAP_MAX);
        if (beats_seen == HOLD_AT_BEAT) stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      beats_seen++;
      if (res_ch.granted) grants++;
      else if (res_ch.wait_ms != '0) rejects++;
      if (verdict_q.size() == 0) begin
        bad_beats++;
        if (bad_beats <= SHOW_MAX)
          $display("%0t: result beat with nothing expected", $realtime);
      end else begin
        want = verdict_q[0];
        verdict_q.delete(0);
        if (res_ch.granted !== want.granted || res_ch.wait_ms !== want.wait_ms ||
            res_ch.busy_res !== want.busy_res || res_ch.tokens_left !== want.tokens_left)
        begin
          bad_beats++;
          if (bad_beats <= SHOW_MAX)
            $display("%0t: beat %0d exp g=%0b w=%0d b=%0b t=%0d got g=%0b w=%0d b=%0b t=%0d",
                     $realtime, beats_seen, want.granted, want.wait_ms, want.busy_res,
                     want.tokens_left, res_ch.granted, res_ch.wait_ms, res_ch.busy_res,
                     res_ch.tokens_left);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    step_row_t         r;
    logic [RATE_W-1:0] phase_rate[RATE_PHASES];
    op_t               op;
    logic [SIZE_W-1:0] size;
    int                pick;
    int                burst;
    int                n;
    bit                paused;

    rst                     = 1'b1;
    cfg_ch.valid            = 1'b0;
    cfg_ch.rate_bytes_per_s = '0;
    item_ch.valid           = 1'b0;
    item_ch.op              = OP_TICK;
    item_ch.request_size    = '0;
    res_ch.ready            = 1'b0;
    rate_now                = '0;
    bucket_level            = '0;
    ms_since_refill         = '0;
    calm                    = 1'b0;
    paused                  = 1'b0;
    beats_seen              = 0;
    beats_drawn             = 0;
    stall_left              = 0;
    bad_beats               = 0;
    items_sent              = 0;
    rate_writes             = 0;
    grants                  = 0;
    rejects                 = 0;
    cycles                  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero rate after reset: busy, refill of one token, saturated wait
    add_check(OP_REQUEST, '0,        1'b1, '0,       1'b1, '0);
    add_check(OP_REQUEST, 48'd1,     1'b1, '0,       1'b1, '0);
    add_check(OP_REQUEST, TOKEN_MAX, 1'b0, WAIT_MAX, 1'b1, 48'd1);
    add_check(OP_NONE,    TOKEN_MAX, 1'b0, '0,       1'b1, 48'd1);
    add_check(OP_TICK,    TOKEN_MAX, 1'b0, '0,       1'b1, 48'd1);
    add_check(OP_RESTART, TOKEN_MAX, 1'b0, '0,       1'b1, '0);
    // full-scale rate: full bucket, bucket saturation on refill
    add_rate(TOKEN_MAX);
    add_check(OP_RESTART, '0,        1'b0, '0, 1'b0, TOKEN_MAX);
    add_check(OP_REQUEST, 48'd1,     1'b1, '0, 1'b0, TOKEN_MAX - 1'b1);
    add_check(OP_TICK,    '0,        1'b0, '0, 1'b0, TOKEN_MAX - 1'b1);
    add_check(OP_REQUEST, TOKEN_MAX, 1'b1, '0, 1'b0, '0);
    add_item(OP_TICK,    '0);
    add_item(OP_TICK,    '0);
    add_item(OP_REQUEST, TOKEN_MAX);
    // one byte per second: huge wait saturates
    add_rate(48'd1);
    add_check(OP_RESTART, '0,        1'b0, '0,       1'b0, 48'd1);
    add_check(OP_REQUEST, 48'd2,     1'b1, '0,       1'b0, '0);
    add_check(OP_REQUEST, TOKEN_MAX, 1'b0, WAIT_MAX, 1'b0, 48'd1);
    // ordinary rates
    add_rate(48'd1000);
    add_check(OP_RESTART, '0, 1'b0, '0, 1'b0, 48'd1000);
    add_item(OP_REQUEST, 48'd1500);
    add_item(OP_TICK,    '0);
    add_item(OP_REQUEST, 48'd600);
    add_rate(48'd3);
    add_item(OP_REQUEST, 48'd7);

    foreach (script[i]) begin
      r = script[i];
      if (r.wr_rate) write_rate(r.arg);
      else send_item(r.op, r.arg, r.typed, r.want);
    end

    // random traffic over several rate settings
    phase_rate[0] = 48'd1000;
    phase_rate[1] = 48'd1;
    phase_rate[2] = RATE_W'($urandom_range(1, 100000));
    phase_rate[3] = rand48();
    phase_rate[4] = '0;
    phase_rate[5] = TOKEN_MAX;
    phase_rate[6] = (rand48() >> $urandom_range(0, 40)) | 48'd1;
    phase_rate[7] = 48'd999;
    n = 0;
    for (int p = 0; p < RATE_PHASES; p++) begin
      write_rate(phase_rate[p]);
      for (int k = 0; k < RANDOM_ITEMS / RATE_PHASES; k++) begin
        // sender waits once for the result stream to run dry
        if (n >= PAUSE_AT && !paused) begin
          paused = 1'b1;
          settle();
        end
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
          // run of ticks to build up elapsed time
          burst = $urandom_range(10, 100);
          for (int t = 0; t < burst; t++) send_item(OP_TICK, rand48(), 1'b0, '0);
          n += burst;
          k += burst - 1;
          continue;
        end
        if (pick < 40) op = OP_TICK;
        else if (pick < 85) op = OP_REQUEST;
        else if (pick < 93) op = OP_RESTART;
        else op = OP_NONE;
        size = rand48();
        if (op == OP_REQUEST) begin
          case ($urandom_range(0, 5))
            0: size = '0;
            1: size = SIZE_W'(64'(rand48()) % (64'(bucket_level) + 64'd1));
            2: size = bucket_level + rand48() % (rate_now / 8 + 48'd2);
            3: size = rand48() >> $urandom_range(0, 47);
            4: size = rand48();
            default: size = rate_now >> $urandom_range(0, 12);
          endcase
        end
        send_item(op, size, 1'b0, '0);
        n++;
      end
    end

    // tick run at full-scale rate, then a refill that falls short of the request
    write_rate(TOKEN_MAX);
    send_item(OP_RESTART, '0, 1'b0, '0);
    send_item(OP_REQUEST, TOKEN_MAX, 1'b0, '0);
    calm = 1'b1;
    for (int t = 0; t < BURST_TICKS; t++) send_item(OP_TICK, '0, 1'b0, '0);
    send_item(OP_REQUEST, TOKEN_MAX, 1'b0, '0);
    calm = 1'b0;

    // drain and let any stray beat show up
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d items under %0d rate writes: %0d grants, %0d rejects, %0d results",
             items_sent, rate_writes, grants, rejects, beats_seen);
    $display("Mismatching or unexpected beats: %0d, results still due: %0d",
             bad_beats, verdict_q.size());
    if (bad_beats == 0 && verdict_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
